// ===== design/jsu_pkg.sv =====
// Shared type, codes and helper function for the JSON string unescaper.
package jsu_pkg;

  // Error codes carried on each result word.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_DANGLING = 3'd1;
  localparam logic [2:0] ERR_TRUNC    = 3'd2;
  localparam logic [2:0] ERR_UNSUP    = 3'd3;
  localparam logic [2:0] ERR_BADHEX   = 3'd4;

  // Characters that the parser looks for.
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // UTF-8 encoding limits and marks.
  localparam logic [15:0] CP_MAX1   = 16'h007f;
  localparam logic [15:0] CP_MAX2   = 16'h07ff;
  localparam logic [7:0]  UTF_LEAD2 = 8'hc0;
  localparam logic [7:0]  UTF_LEAD3 = 8'he0;
  localparam logic [7:0]  UTF_CONT  = 8'h80;

  // Depth of the queue between the parser and the output serialiser.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // One parsed input word: one to three result words waiting to be sent.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic            byte_valid;
    logic [2:0]      error_code;
    logic            eos;
  } jsu_entry_t;

  // Value of a hex digit; bit 4 set marks a byte that is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

endpackage

// ===== design/jsu_front.sv =====
// Parser: accepts escaped bytes and turns them into queue entries of results.
module jsu_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              q_full,
  output logic              in_stall,
  output logic              push,
  output jsu_pkg::jsu_entry_t push_entry
);
  import jsu_pkg::*;

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESCAPE = 3'd1;
  localparam logic [2:0] MODE_HEX1   = 3'd2;
  localparam logic [2:0] MODE_HEX2   = 3'd3;
  localparam logic [2:0] MODE_HEX3   = 3'd4;
  localparam logic [2:0] MODE_HEX4   = 3'd5;
  localparam logic [2:0] MODE_DROP   = 3'd6;

  logic [2:0]  mode, mode_next;
  logic [11:0] acc, acc_next;
  logic [4:0]  dig;
  logic [15:0] cp;
  logic        accept;
  jsu_entry_t  ent;

  // Input is held off only while the queue has no room.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign dig      = hex_value(in_byte);
  assign cp       = {acc, dig[3:0]};

  // Classify the byte against the current parse mode.
  always_comb begin
    ent            = '0;
    ent.error_code = ERR_NONE;
    mode_next      = mode;
    acc_next       = acc;
    unique case (mode)
      MODE_ESCAPE: begin
        mode_next = MODE_NORMAL;
        ent.count = 2'd1;
        ent.byte_valid = 1'b1;
        ent.eos = in_last;
        unique case (in_byte)
          CH_BSLASH: ent.bytes[0] = CH_BSLASH;
          CH_QUOTE:  ent.bytes[0] = CH_QUOTE;
          CH_SLASH:  ent.bytes[0] = CH_SLASH;
          CH_B:      ent.bytes[0] = 8'h08;
          CH_F:      ent.bytes[0] = 8'h0c;
          CH_N:      ent.bytes[0] = 8'h0a;
          CH_R:      ent.bytes[0] = 8'h0d;
          CH_T:      ent.bytes[0] = 8'h09;
          CH_U: begin
            ent.byte_valid = 1'b0;
            acc_next = '0;
            if (in_last) begin
              ent.error_code = ERR_TRUNC;
            end else begin
              ent.count = 2'd0;
              mode_next = MODE_HEX1;
            end
          end
          default: begin
            ent.byte_valid = 1'b0;
            ent.error_code = ERR_UNSUP;
            mode_next = in_last ? MODE_NORMAL : MODE_DROP;
            acc_next = '0;
          end
        endcase
      end
      MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        if (in_last) begin
          ent.count = 2'd1;
          ent.error_code = ERR_TRUNC;
          ent.eos = 1'b1;
          mode_next = MODE_NORMAL;
          acc_next = '0;
        end else if (dig[4]) begin
          ent.count = 2'd1;
          ent.error_code = ERR_BADHEX;
          mode_next = MODE_DROP;
          acc_next = '0;
        end else begin
          acc_next = {acc[7:0], dig[3:0]};
          mode_next = mode + 3'd1;
        end
      end
      MODE_HEX4: begin
        mode_next = MODE_NORMAL;
        acc_next = '0;
        ent.eos = in_last;
        if (dig[4]) begin
          ent.count = 2'd1;
          ent.error_code = ERR_BADHEX;
          mode_next = in_last ? MODE_NORMAL : MODE_DROP;
        end else begin
          // UTF-8 encoding of the 16-bit code point.
          ent.byte_valid = 1'b1;
          if (cp <= CP_MAX1) begin
            ent.count = 2'd1;
            ent.bytes[0] = cp[7:0];
          end else if (cp <= CP_MAX2) begin
            ent.count = 2'd2;
            ent.bytes[0] = UTF_LEAD2 | {3'b000, cp[10:6]};
            ent.bytes[1] = UTF_CONT | {2'b00, cp[5:0]};
          end else begin
            ent.count = 2'd3;
            ent.bytes[0] = UTF_LEAD3 | {4'b0000, cp[15:12]};
            ent.bytes[1] = UTF_CONT | {2'b00, cp[11:6]};
            ent.bytes[2] = UTF_CONT | {2'b00, cp[5:0]};
          end
        end
      end
      MODE_DROP: begin
        if (in_last) begin
          ent.count = 2'd1;
          ent.eos = 1'b1;
          mode_next = MODE_NORMAL;
          acc_next = '0;
        end
      end
      default: begin
        // Normal mode, and the unused mode code.
        if (in_byte == CH_BSLASH) begin
          if (in_last) begin
            ent.count = 2'd1;
            ent.error_code = ERR_DANGLING;
            ent.eos = 1'b1;
            mode_next = MODE_NORMAL;
            acc_next = '0;
          end else begin
            mode_next = MODE_ESCAPE;
          end
        end else begin
          ent.count = 2'd1;
          ent.bytes[0] = in_byte;
          ent.byte_valid = 1'b1;
          ent.eos = in_last;
          mode_next = MODE_NORMAL;
          acc_next = '0;
        end
      end
    endcase
  end

  assign push       = accept && (ent.count != 2'd0);
  assign push_entry = ent;

  // Parse state advances on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      acc  <= '0;
    end else if (accept) begin
      mode <= mode_next;
      acc  <= acc_next;
    end
  end

endmodule

// ===== design/jsu_queue.sv =====
// Short queue of parsed entries between the parser and the serialiser.
module jsu_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  jsu_pkg::jsu_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output jsu_pkg::jsu_entry_t head
);
  import jsu_pkg::*;

  jsu_entry_t          mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/jsu_back.sv =====
// Serialiser: sends the result words of each queue entry through an output register.
module jsu_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_not_empty,
  input  jsu_pkg::jsu_entry_t q_head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                byte_valid,
  output logic [2:0]          error_code,
  output logic                end_of_string
);
  import jsu_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       final_word;
  logic [7:0] sel_byte;

  // A new word enters the output register when it is empty or being taken.
  assign load       = q_not_empty && (!out_valid || !out_stall);
  assign final_word = (idx == q_head.count - 2'd1);
  assign pop        = load && final_word;

  // Pick the byte for the current position within the entry.
  always_comb begin
    unique case (idx)
      2'd0:    sel_byte = q_head.bytes[0];
      2'd1:    sel_byte = q_head.bytes[1];
      2'd2:    sel_byte = q_head.bytes[2];
      default: sel_byte = '0;
    endcase
  end

  // Output register control and position counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_word ? 2'd0 : idx + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload; error and end flags go only on the entry's final word.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= sel_byte;
      byte_valid    <= q_head.byte_valid;
      error_code    <= final_word ? q_head.error_code : ERR_NONE;
      end_of_string <= final_word && q_head.eos;
    end
  end

endmodule

// ===== design/json_string_unescape.sv =====
// Top level of the JSON string unescaper.
//
// Input channel (in_valid, in_stall, in_byte, in_last) takes one escaped
// byte of a JSON string body per word; in_last marks the final byte.
// Output channel (out_valid, out_stall, out_byte, byte_valid, error_code,
// end_of_string) gives the decoded bytes, error reports and end markers.
// An accepted word goes through the queue and then the output register.
// The parser takes one input word per cycle while the queue is not full; a word may
// yield zero to three result words, and the serialiser sends one result word per
// cycle while out_stall is low. A backslash-u escape takes six input words for at
// most three results, so with no receiver stall the input runs at one word per
// cycle with no gap. A four-entry queue between parser and serialiser absorbs the
// bursts. When the receiver stalls, the output word holds, the queue fills and
// in_stall rises once it is full. Synchronous reset empties the queue and
// the output register and returns the parser to normal byte mode.
module json_string_unescape (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic [2:0] error_code,
  output logic       end_of_string
);
  import jsu_pkg::*;

  logic       push, pop, q_full, q_not_empty;
  jsu_entry_t push_entry, q_head;

  // Parser front.
  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .q_full     (q_full),
    .in_stall   (in_stall),
    .push       (push),
    .push_entry (push_entry)
  );

  // Entry queue.
  jsu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // Output serialiser.
  jsu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .error_code    (error_code),
    .end_of_string (end_of_string)
  );

endmodule
